// ===== sv/lc4_instruction_execute_defines.svh =====
// Assertion macros for the LC4 execute block
`ifndef LC4_INSTRUCTION_EXECUTE_DEFINES_SVH
`define LC4_INSTRUCTION_EXECUTE_DEFINES_SVH
`ifndef ASSERT_OFF
`define LC4_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define LC4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LC4_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define LC4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/lc4_pkg.sv =====
package lc4_pkg;

    localparam logic [3:0] OP_BR      = 4'd0;
    localparam logic [3:0] OP_ARITH   = 4'd1;
    localparam logic [3:0] OP_CMP     = 4'd2;
    localparam logic [3:0] OP_JSR     = 4'd4;
    localparam logic [3:0] OP_LOGIC   = 4'd5;
    localparam logic [3:0] OP_LDR     = 4'd6;
    localparam logic [3:0] OP_STR     = 4'd7;
    localparam logic [3:0] OP_RTI     = 4'd8;
    localparam logic [3:0] OP_CONST   = 4'd9;
    localparam logic [3:0] OP_SHIFT   = 4'd10;
    localparam logic [3:0] OP_JMP     = 4'd12;
    localparam logic [3:0] OP_HICONST = 4'd13;
    localparam logic [3:0] OP_TRAP    = 4'd15;

    localparam logic [2:0] NZP_N = 3'h4;
    localparam logic [2:0] NZP_Z = 3'h2;
    localparam logic [2:0] NZP_P = 3'h1;

    localparam logic [15:0] USER_CODE_TOP = 16'h1FFF;
    localparam logic [15:0] USER_DATA_LO  = 16'h2000;
    localparam logic [15:0] USER_DATA_HI  = 16'h7FFF;
    localparam logic [15:0] OS_CODE_LO    = 16'h8000;
    localparam logic [15:0] OS_CODE_HI    = 16'h9FFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_MEM,
        ST_DONE
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic div_start;
        logic div_step;
        logic div_finish;
        logic mem_finish;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;
        logic need_mem;
        logic div_last;
    } dp_status_t;

    function automatic logic [2:0] flags_of(input logic [15:0] v);
        if (v == 16'd0) begin
            return NZP_Z;
        end
        return v[15] ? NZP_N : NZP_P;
    endfunction

endpackage

// ===== sv/lc4_ctrl.sv =====
module lc4_ctrl
    import lc4_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       req_valid,
    output logic       req_ready,
    output logic       res_valid,
    input  logic       res_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    // advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (req_valid) state_next = ST_EXEC;
            ST_EXEC: begin
                if (status.need_div) state_next = ST_DIV;
                else if (status.need_mem) state_next = ST_MEM;
                else state_next = ST_DONE;
            end
            ST_DIV: if (status.div_last) state_next = ST_DONE;
            ST_MEM: state_next = ST_DONE;
            ST_DONE: if (res_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd = '0;
        req_ready = 1'b0;
        res_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                cmd.load = req_valid;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                cmd.div_start = status.need_div;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cmd.div_finish = status.div_last;
            end
            ST_MEM: cmd.mem_finish = 1'b1;
            ST_DONE: res_valid = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== sv/lc4_datapath.sv =====
module lc4_datapath
    import lc4_pkg::*;
#(
    parameter int MEM_WORDS = 65536,
    parameter int REG_COUNT = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic        in_cmd,
    input  logic [15:0] in_pc,
    input  logic [15:0] in_instruction,
    input  logic [15:0] in_preload_address,
    input  logic [15:0] in_preload_data,
    output logic [15:0] next_pc,
    output logic        access_fault,
    output logic        bad_opcode,
    output logic [2:0]  nzp_flags,
    output logic        privileged
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam int RW = $clog2(REG_COUNT);

    logic [15:0] mem [MEM_WORDS];
    logic [15:0] rf_reg [REG_COUNT];
    logic [2:0]  nzp_reg;
    logic        priv_reg, fault_reg;

    logic        cmd_reg;
    logic [15:0] pc_reg, ins_reg, pa_reg, pd_reg;
    logic [15:0] npc_reg, npc_next;
    logic        bad_reg, bad_next;

    // divider
    logic [15:0] quo_reg, rem_reg, dvs_reg;
    logic [3:0]  cnt_reg;
    logic        is_mod_reg;
    logic [RW-1:0] div_dst_reg;
    logic [16:0] rem_sh;
    logic [15:0] quo_sh, rem_new;
    logic        take;

    logic [15:0] mem_q;
    logic [RW-1:0] ld_dst_reg;

    // decode
    logic [3:0]  op;
    logic [RW-1:0] rd, rs, rt;
    logic [15:0] vs, vt, vd;
    logic [15:0] addr;
    logic        pc_ok, data_ok, fault_now;
    logic        wr_en, wr_flags;
    logic [RW-1:0] wr_idx;
    logic [15:0] wr_val;
    logic        cmp_en;
    logic [2:0]  cmp_flags;
    logic        set_priv, clr_priv, ld_go, st_go, div_go;
    logic [3:0]  sh;
    logic [16:0] cmp_a, cmp_b;
    logic [31:0] prod;

    assign op = ins_reg[15:12];
    assign rd = ins_reg[11:9];
    assign rs = ins_reg[8:6];
    assign rt = ins_reg[2:0];
    assign vs = rf_reg[rs];
    assign vt = rf_reg[rt];
    assign vd = rf_reg[rd];
    assign sh = ins_reg[3:0];
    assign addr = vs + {{10{ins_reg[5]}}, ins_reg[5:0]};
    assign prod = vs * vt;

    always_comb begin
        if (priv_reg) begin
            pc_ok = !(pc_reg >= USER_DATA_LO && pc_reg <= USER_DATA_HI) && pc_reg <= OS_CODE_HI;
            data_ok = addr >= USER_DATA_LO && !(addr >= OS_CODE_LO && addr <= OS_CODE_HI);
        end else begin
            pc_ok = pc_reg <= USER_CODE_TOP;
            data_ok = addr >= USER_DATA_LO && addr <= USER_DATA_HI;
        end
    end

    // execute one instruction
    always_comb begin
        npc_next = pc_reg + 16'd1;
        bad_next = 1'b0;
        fault_now = 1'b0;
        wr_en = 1'b0;
        wr_flags = 1'b1;
        wr_idx = rd;
        wr_val = '0;
        cmp_en = 1'b0;
        cmp_a = '0;
        cmp_b = '0;
        set_priv = 1'b0;
        clr_priv = 1'b0;
        ld_go = 1'b0;
        st_go = 1'b0;
        div_go = 1'b0;
        if (cmd_reg) begin
            npc_next = '0;
        end else if (!pc_ok) begin
            npc_next = '0;
            fault_now = 1'b1;
        end else begin
            case (op)
                OP_BR: if ((ins_reg[11:9] & nzp_reg) != 3'd0)
                    npc_next = pc_reg + 16'd1 + {{7{ins_reg[8]}}, ins_reg[8:0]};
                OP_ARITH: begin
                    wr_en = 1'b1;
                    if (ins_reg[5]) wr_val = vs + {{11{ins_reg[4]}}, ins_reg[4:0]};
                    else case (ins_reg[4:3])
                        2'd0: wr_val = vs + vt;
                        2'd1: wr_val = prod[15:0];
                        2'd2: wr_val = vs - vt;
                        default: begin
                            wr_en = 1'b0;
                            div_go = 1'b1;
                        end
                    endcase
                end
                OP_CMP: begin
                    cmp_en = 1'b1;
                    case (ins_reg[8:7])
                        2'd0: begin cmp_a = {vd[15], vd}; cmp_b = {vt[15], vt}; end
                        2'd1: begin cmp_a = {1'b0, vd}; cmp_b = {1'b0, vt}; end
                        2'd2: begin
                            cmp_a = {vd[15], vd};
                            cmp_b = {{10{ins_reg[6]}}, ins_reg[6:0]};
                        end
                        default: begin cmp_a = {1'b0, vd}; cmp_b = {10'd0, ins_reg[6:0]}; end
                    endcase
                end
                OP_JSR: begin
                    wr_en = 1'b1;
                    wr_flags = 1'b0;
                    wr_idx = RW'(7);
                    wr_val = pc_reg + 16'd1;
                    if (ins_reg[11]) npc_next = {pc_reg[15], ins_reg[10:0], 4'd0};
                    else npc_next = vs;
                end
                OP_LOGIC: begin
                    wr_en = 1'b1;
                    if (ins_reg[5]) wr_val = vs & {{11{ins_reg[4]}}, ins_reg[4:0]};
                    else case (ins_reg[4:3])
                        2'd0: wr_val = vs & vt;
                        2'd1: wr_val = ~vs;
                        2'd2: wr_val = vs | vt;
                        default: wr_val = vs ^ vt;
                    endcase
                end
                OP_LDR, OP_STR: begin
                    if (!data_ok || (op == OP_STR && pc_reg < USER_DATA_LO && addr > USER_DATA_HI)) begin
                        fault_now = 1'b1;
                        npc_next = '0;
                    end else if (op == OP_LDR) begin
                        ld_go = 1'b1;
                    end else begin
                        st_go = 1'b1;
                    end
                end
                OP_RTI: begin
                    npc_next = rf_reg[RW'(7)];
                    clr_priv = 1'b1;
                end
                OP_CONST: begin
                    wr_en = 1'b1;
                    wr_val = {{7{ins_reg[8]}}, ins_reg[8:0]};
                end
                OP_SHIFT: begin
                    wr_en = 1'b1;
                    case (ins_reg[5:4])
                        2'd0: wr_val = vs << sh;
                        2'd1: wr_val = 16'($signed(vs) >>> sh);
                        2'd2: wr_val = vs >> sh;
                        default: begin
                            wr_en = 1'b0;
                            div_go = 1'b1;
                        end
                    endcase
                end
                OP_JMP: begin
                    if (ins_reg[11]) npc_next = pc_reg + 16'd1 + {{5{ins_reg[10]}}, ins_reg[10:0]};
                    else npc_next = vs;
                end
                OP_HICONST: begin
                    wr_en = 1'b1;
                    wr_val = {ins_reg[7:0], vd[7:0]};
                end
                OP_TRAP: begin
                    wr_en = 1'b1;
                    wr_flags = 1'b0;
                    wr_idx = RW'(7);
                    wr_val = pc_reg + 16'd1;
                    npc_next = {8'h80, ins_reg[7:0]};
                    set_priv = 1'b1;
                end
                default: begin
                    bad_next = 1'b1;
                    npc_next = pc_reg;
                end
            endcase
        end
    end

    logic [16:0] cmp_diff;
    assign cmp_diff = cmp_a - cmp_b;
    assign cmp_flags = (cmp_diff == 17'd0) ? NZP_Z : (cmp_diff[16] ? NZP_N : NZP_P);

    assign status.need_div = div_go;
    assign status.need_mem = ld_go;
    assign status.div_last = cnt_reg == 4'd15;

    // one restoring divide step per cycle
    assign rem_sh = {rem_reg, quo_reg[15]};
    assign take = rem_sh >= {1'b0, dvs_reg};
    assign rem_new = take ? 16'(rem_sh - {1'b0, dvs_reg}) : rem_sh[15:0];
    assign quo_sh = {quo_reg[14:0], take};

    // capture request and execute results
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= in_cmd;
            pc_reg  <= in_pc;
            ins_reg <= in_instruction;
            pa_reg  <= in_preload_address;
            pd_reg  <= in_preload_data;
        end
        if (cmd.exec) begin
            npc_reg <= npc_next;
            bad_reg <= bad_next;
        end
    end

    // memory port
    always_ff @(posedge aclk) begin
        if (cmd.exec && cmd_reg) mem[pa_reg[AW-1:0]] <= pd_reg;
        else if (cmd.exec && st_go) mem[addr[AW-1:0]] <= vd;
        mem_q <= mem[addr[AW-1:0]];
    end

    // divider state
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            quo_reg <= vs;
            rem_reg <= '0;
            dvs_reg <= vt;
            cnt_reg <= '0;
            is_mod_reg <= op == OP_SHIFT;
            div_dst_reg <= rd;
        end else if (cmd.div_step) begin
            quo_reg <= quo_sh;
            rem_reg <= rem_new;
            cnt_reg <= cnt_reg + 4'd1;
        end
        if (cmd.exec) ld_dst_reg <= rd;
    end

    logic [15:0] div_res;
    assign div_res = (dvs_reg == 16'd0) ? 16'd0 : (is_mod_reg ? rem_new : quo_sh);

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) rf_reg[i] <= '0;
            nzp_reg <= NZP_Z;
            priv_reg <= 1'b0;
            fault_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                if (wr_en) begin
                    rf_reg[wr_idx] <= wr_val;
                    if (wr_flags) nzp_reg <= flags_of(wr_val);
                end
                if (cmp_en) nzp_reg <= cmp_flags;
                if (set_priv) priv_reg <= 1'b1;
                if (clr_priv) priv_reg <= 1'b0;
                if (fault_now) fault_reg <= 1'b1;
            end
            if (cmd.div_finish) begin
                rf_reg[div_dst_reg] <= div_res;
                nzp_reg <= flags_of(div_res);
            end
            if (cmd.mem_finish) begin
                rf_reg[ld_dst_reg] <= mem_q;
                nzp_reg <= flags_of(mem_q);
            end
        end
    end

    assign next_pc = npc_reg;
    assign bad_opcode = bad_reg;
    assign access_fault = fault_reg;
    assign nzp_flags = nzp_reg;
    assign privileged = priv_reg;

endmodule

// ===== sv/lc4_instruction_execute.sv =====
// Channel  | Dir | Payload
// s_axis   | in  | tuser: cmd; tdata: pc, instruction, preload_address, preload_data
// m_axis   | out | tdata: next_pc, access_fault, bad_opcode, nzp_flags, privileged
// One request at a time. Preload and most instructions pass the execute and
// done states; LDR adds a memory state; DIV and MOD add the 16 radix-2 steps
// of the shared divider. The block returns to idle after each result. Reset is
// synchronous, active-low: it clears the register file, fault and privilege and
// sets flags to Z. Memory holds no reset value; a stalled result holds the block.
`include "lc4_instruction_execute_defines.svh"
module lc4_instruction_execute
    import lc4_pkg::*;
#(
    parameter int MEM_WORDS = 65536,
    parameter int REG_COUNT = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[0]
    input  logic        s_axis_tuser,
    // pc[15:0], instruction[31:16], preload_address[47:32], preload_data[63:48]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // next_pc[15:0], access_fault[16], bad_opcode[17], nzp_flags[20:18], privileged[21]
    output logic [23:0] m_axis_tdata
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [15:0] next_pc;
    logic        access_fault, bad_opcode, privileged;
    logic [2:0]  nzp_flags;

    lc4_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .req_valid(s_axis_tvalid), .req_ready(s_axis_tready),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
        .status(status), .cmd(cmd)
    );

    lc4_datapath #(.MEM_WORDS(MEM_WORDS), .REG_COUNT(REG_COUNT)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .in_cmd(s_axis_tuser), .in_pc(s_axis_tdata[15:0]),
        .in_instruction(s_axis_tdata[31:16]), .in_preload_address(s_axis_tdata[47:32]),
        .in_preload_data(s_axis_tdata[63:48]),
        .next_pc(next_pc), .access_fault(access_fault), .bad_opcode(bad_opcode),
        .nzp_flags(nzp_flags), .privileged(privileged)
    );

    assign m_axis_tdata = {2'b00, privileged, nzp_flags, bad_opcode, access_fault, next_pc};

    `LC4_ASSERT_IMPL(a_no_overlap, aclk, aresetn, m_axis_tvalid, !s_axis_tready, "overlap")
    `LC4_ASSERT_IMPL(a_flags_onehot, aclk, aresetn, 1'b1, $onehot(nzp_flags), "flags")
    `LC4_ASSERT_NEXT(a_fault_sticky, aclk, aresetn, access_fault, access_fault, "fault")

endmodule
